@@ hw/rtl/pinhole_project_with_jacobian_defines.svh @@
// Assertion macros used by the pinhole projection checker
`ifndef PINHOLE_PROJECT_WITH_JACOBIAN_DEFINES_SVH
`define PINHOLE_PROJECT_WITH_JACOBIAN_DEFINES_SVH

// assert with reset disable
`define PINHOLE_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assert with no reset disable
`define PINHOLE_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/pinhole_pkg.sv @@
// Shared types and register codes of the pinhole projection block
`timescale 1ns / 1ps
package pinhole_pkg;

  localparam int NUM_LANES = 6;

  localparam logic [1:0] REG_FOCAL_X  = 2'd0;
  localparam logic [1:0] REG_FOCAL_Y  = 2'd1;
  localparam logic [1:0] REG_CENTER_X = 2'd2;
  localparam logic [1:0] REG_CENTER_Y = 2'd3;

  typedef struct packed {
    logic       invalid;
    logic       xneg;
    logic       yneg;
    logic       xpos;
    logic       ypos;
    logic [5:0] ovf;
  } side_t;

endpackage

@@ hw/rtl/pinhole_project_with_jacobian.sv @@
// A start passes stages 1 and 2, the divider and the output register before done.
// Throughput: one word per cycle; busy is always low, the pipeline never stalls.
// The depth is set by the divider: one quotient bit per stage, six lanes side by side.
// Reset clears all pipeline valid bits and restores focal lengths and center.
// done marks each result for exactly one cycle.
`timescale 1ns / 1ps
module pinhole_project_with_jacobian #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16,
  localparam int DATA_W = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_W = (COORD_WIDTH > 32) ? 5 : 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] pixel_u,
  output logic signed [COORD_WIDTH-1:0] pixel_v,
  output logic signed [COORD_WIDTH-1:0] du_dx,
  output logic signed [COORD_WIDTH-1:0] du_dz,
  output logic signed [COORD_WIDTH-1:0] dv_dy,
  output logic signed [COORD_WIDTH-1:0] dv_dz,
  output logic                          depth_invalid,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  localparam int W  = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int QB = W + 1;
  localparam int NW = 2 * W + F;
  localparam int NL = pinhole_pkg::NUM_LANES;

  localparam logic [W-1:0] FOCAL_RST = W'(64'd500 << F);
  localparam logic [W-1:0] CX_RST    = W'(64'd320 << F);
  localparam logic [W-1:0] CY_RST    = W'(64'd240 << F);

  logic [W-1:0] focal_x;
  logic [W-1:0] focal_y;
  logic [W-1:0] center_x;
  logic [W-1:0] center_y;
  logic [1:0]   reg_sel;
  logic         wr_en;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_sel = paddr[ADDR_W-1:ADDR_W-2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= FOCAL_RST;
      focal_y  <= FOCAL_RST;
      center_x <= CX_RST;
      center_y <= CY_RST;
    end else if (wr_en) begin
      case (reg_sel)
        pinhole_pkg::REG_FOCAL_X:  focal_x  <= pwdata[W-1:0];
        pinhole_pkg::REG_FOCAL_Y:  focal_y  <= pwdata[W-1:0];
        pinhole_pkg::REG_CENTER_X: center_x <= pwdata[W-1:0];
        pinhole_pkg::REG_CENTER_Y: center_y <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pinhole_pkg::REG_FOCAL_X:  prdata = DATA_W'(focal_x);
      pinhole_pkg::REG_FOCAL_Y:  prdata = DATA_W'(focal_y);
      pinhole_pkg::REG_CENTER_X: prdata = DATA_W'(center_x);
      pinhole_pkg::REG_CENTER_Y: prdata = DATA_W'(center_y);
      default:                   prdata = '0;
    endcase
  end

  // stage 1: magnitudes and signs
  logic              s1_valid;
  logic [W-1:0]      s1_ax;
  logic [W-1:0]      s1_ay;
  logic [W-1:0]      s1_z;
  pinhole_pkg::side_t s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_ax <= point_x[W-1] ? W'(-point_x) : point_x;
    s1_ay <= point_y[W-1] ? W'(-point_y) : point_y;
    s1_z  <= point_z;
    s1_side.invalid <= (point_z <= 0);
    s1_side.xneg    <= point_x[W-1];
    s1_side.yneg    <= point_y[W-1];
    s1_side.xpos    <= !point_x[W-1] && (point_x != 0);
    s1_side.ypos    <= !point_y[W-1] && (point_y != 0);
    s1_side.ovf     <= '0;
  end

  // stage 2: products
  logic              s2_valid;
  logic [2*W-1:0]    s2_fxx;
  logic [2*W-1:0]    s2_fyy;
  logic [2*W-1:0]    s2_zz;
  logic [W-1:0]      s2_z;
  pinhole_pkg::side_t s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_fxx  <= (2*W)'(focal_x) * (2*W)'(s1_ax);
    s2_fyy  <= (2*W)'(focal_y) * (2*W)'(s1_ay);
    s2_zz   <= (2*W)'(s1_z) * (2*W)'(s1_z);
    s2_z    <= s1_z;
    s2_side <= s1_side;
  end

  // stage 3: numerators, overflow check, initial remainders
  logic [NW-1:0]  num [NL];
  logic [2*W-1:0] den [NL];
  logic [NW-1:0]  num_hi [NL];
  logic [5:0]     ovf_init;
  pinhole_pkg::side_t side_init;

  always_comb begin
    num[0] = {{F{1'b0}}, s2_fxx};
    num[1] = {{F{1'b0}}, s2_fyy};
    num[2] = {{W{1'b0}}, focal_x, {F{1'b0}}};
    num[3] = {s2_fxx, {F{1'b0}}};
    num[4] = {{W{1'b0}}, focal_y, {F{1'b0}}};
    num[5] = {s2_fyy, {F{1'b0}}};
    den[0] = {{W{1'b0}}, s2_z};
    den[1] = {{W{1'b0}}, s2_z};
    den[2] = {{W{1'b0}}, s2_z};
    den[3] = s2_zz;
    den[4] = {{W{1'b0}}, s2_z};
    den[5] = s2_zz;
    for (int l = 0; l < NL; l++) begin
      num_hi[l]   = num[l] >> QB;
      ovf_init[l] = num_hi[l] >= {{F{1'b0}}, den[l]};
    end
    side_init     = s2_side;
    side_init.ovf = ovf_init;
  end

  logic [QB:0]        dv_valid;
  logic [2*W-1:0]     dv_rem  [QB+1][NL];
  logic [QB-1:0]      dv_num  [QB+1][NL];
  logic [QB-1:0]      dv_quo  [QB+1][NL];
  logic [W-1:0]       dv_z    [QB+1];
  logic [2*W-1:0]     dv_zz   [QB+1];
  pinhole_pkg::side_t dv_side [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NL; l++) begin
      dv_rem[0][l] <= num_hi[l][2*W-1:0];
      dv_num[0][l] <= num[l][QB-1:0];
      dv_quo[0][l] <= '0;
    end
    dv_z[0]          <= s2_z;
    dv_zz[0]         <= s2_zz;
    dv_side[0]       <= side_init;
  end

  // divider: one quotient bit per stage per lane
  for (genvar s = 1; s <= QB; s++) begin : g_div
    logic [2*W:0]   trial [NL];
    logic [2*W-1:0] dsr   [NL];
    logic [NL-1:0]  ge;

    always_comb begin
      for (int l = 0; l < NL; l++) begin
        dsr[l]   = (l == 3 || l == 5) ? dv_zz[s-1] : {{W{1'b0}}, dv_z[s-1]};
        trial[l] = {dv_rem[s-1][l], dv_num[s-1][l][QB-1]};
        ge[l]    = trial[l] >= {1'b0, dsr[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[s] <= 1'b0;
      end else begin
        dv_valid[s] <= dv_valid[s-1];
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < NL; l++) begin
        dv_rem[s][l] <= ge[l] ? (2*W)'(trial[l] - {1'b0, dsr[l]}) : trial[l][2*W-1:0];
        dv_num[s][l] <= {dv_num[s-1][l][QB-2:0], 1'b0};
        dv_quo[s][l] <= {dv_quo[s-1][l][QB-2:0], ge[l]};
      end
      dv_z[s]    <= dv_z[s-1];
      dv_zz[s]   <= dv_zz[s-1];
      dv_side[s] <= dv_side[s-1];
    end
  end

  // output stage: cap, sign, offset, saturate, zero on invalid depth
  localparam logic [QB-1:0] CAP = {1'b1, {W{1'b0}}};
  localparam logic signed [W+2:0] SMAX = (W+3)'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [W+2:0] SMIN = -SMAX - 1;

  logic [QB-1:0]        mag  [NL];
  logic [NL-1:0]        neg;
  logic [W-1:0]         offs [NL];
  logic signed [W+2:0]  sval [NL];
  logic [W-1:0]         res  [NL];
  pinhole_pkg::side_t   fin;

  assign fin = dv_side[QB];

  always_comb begin
    neg  = {fin.ypos, 1'b0, fin.xpos, 1'b0, fin.yneg, fin.xneg};
    offs[0] = center_x;
    offs[1] = center_y;
    for (int l = 2; l < NL; l++) begin
      offs[l] = '0;
    end
    for (int l = 0; l < NL; l++) begin
      mag[l]  = (fin.ovf[l] || dv_quo[QB][l] > CAP) ? CAP : dv_quo[QB][l];
      sval[l] = neg[l] ? -$signed({2'b00, mag[l]}) : $signed({2'b00, mag[l]});
      sval[l] = sval[l] + $signed({{3{offs[l][W-1]}}, offs[l]});
      if (fin.invalid) begin
        res[l] = '0;
      end else if (sval[l] > SMAX) begin
        res[l] = SMAX[W-1:0];
      end else if (sval[l] < SMIN) begin
        res[l] = SMIN[W-1:0];
      end else begin
        res[l] = sval[l][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    pixel_u       <= res[0];
    pixel_v       <= res[1];
    du_dx         <= res[2];
    du_dz         <= res[3];
    dv_dy         <= res[4];
    dv_dz         <= res[5];
    depth_invalid <= fin.invalid;
  end

endmodule

@@ hw/rtl/pinhole_checker.sv @@
// Port-level checker for the pinhole projection block, with its bind
`timescale 1ns / 1ps
`include "pinhole_project_with_jacobian_defines.svh"
module pinhole_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic signed [COORD_WIDTH-1:0] point_z,
  input logic                          done,
  input logic signed [COORD_WIDTH-1:0] pixel_u,
  input logic signed [COORD_WIDTH-1:0] pixel_v,
  input logic signed [COORD_WIDTH-1:0] du_dx,
  input logic signed [COORD_WIDTH-1:0] du_dz,
  input logic signed [COORD_WIDTH-1:0] dv_dy,
  input logic signed [COORD_WIDTH-1:0] dv_dz,
  input logic                          depth_invalid
);

  localparam int LAT = COORD_WIDTH + 5;

  logic z_nonpos;
  logic all_zero;

  assign z_nonpos = point_z <= 0;
  assign all_zero = pixel_u == 0 && pixel_v == 0 && du_dx == 0 && du_dz == 0 &&
                    dv_dy == 0 && dv_dz == 0;

  `PINHOLE_ASSERT_ALWAYS(a_never_busy, clk, !busy, "busy raised")
  `PINHOLE_ASSERT(a_start_done, clk, rst, start && !rst |-> ##LAT done, "result word lost")
  `PINHOLE_ASSERT(a_done_start, clk, rst, done |-> $past(start && !rst, LAT), "word invented")
  `PINHOLE_ASSERT(a_invalid_flag, clk, rst, done |-> depth_invalid == $past(z_nonpos, LAT), "bad flag")
  `PINHOLE_ASSERT(a_invalid_zero, clk, rst, done && depth_invalid |-> all_zero, "word not zero")

endmodule

bind pinhole_project_with_jacobian pinhole_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_pinhole_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .point_z(point_z),
  .done(done),
  .pixel_u(pixel_u),
  .pixel_v(pixel_v),
  .du_dx(du_dx),
  .du_dz(du_dz),
  .dv_dy(dv_dy),
  .dv_dz(dv_dz),
  .depth_invalid(depth_invalid)
);
